// ===== hw/rtl/spt_pkg.sv =====
package spt_pkg;

  localparam int POS_W    = 16;
  localparam int SUM_W    = 15;
  localparam int CENTER_W = 12;
  localparam int STEP_W   = 4;
  localparam int TSUM_W   = 14;
  localparam int NET_W    = 15;
  localparam int DIM_W    = 12;
  localparam int DRIFT_LIMIT_SQ = 25;

  typedef logic signed [POS_W-1:0] pos_t;

  typedef struct packed {
    logic [11:0] frame_width;
    logic [11:0] frame_height;
    logic [11:0] start_x;
    logic [11:0] start_y;
    logic [15:0] skip_frames;
    logic [7:0]  edge_margin;
    logic [7:0]  sky_offset;
    logic        track_enable;
  } spt_cfg_t;

  localparam spt_cfg_t CFG_RESET = '{
    frame_width:  12'd640,
    frame_height: 12'd480,
    start_x:      12'd0,
    start_y:      12'd0,
    skip_frames:  16'd0,
    edge_margin:  8'd30,
    sky_offset:   8'd10,
    track_enable: 1'b1
  };

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_START_X      = 3'd2,
    REG_START_Y      = 3'd3,
    REG_SKIP_FRAMES  = 3'd4,
    REG_EDGE_MARGIN  = 3'd5,
    REG_SKY_OFFSET   = 3'd6,
    REG_TRACK_ENABLE = 3'd7
  } spt_reg_t;

  localparam logic [1:0] STAT_TRACKED = 2'd0;
  localparam logic [1:0] STAT_EDGE    = 2'd1;
  localparam logic [1:0] STAT_DRIFT   = 2'd2;

  // A zero size acts as one
  function automatic logic [DIM_W:0] eff_dim(input logic [DIM_W-1:0] d);
    return (d == '0) ? (DIM_W+1)'(1) : {1'b0, d};
  endfunction

  function automatic pos_t to_pos(input logic [DIM_W:0] d);
    return pos_t'({{(POS_W-DIM_W-1){1'b0}}, d});
  endfunction

  // Sky start: toward the frame centre by sky_offset
  function automatic pos_t sky_init(input logic [DIM_W-1:0] s, input logic [DIM_W-1:0] d,
                                    input logic [7:0] off);
    logic [DIM_W:0] half;
    pos_t sp;
    pos_t op;
    half = eff_dim(d) >> 1;
    sp   = to_pos({1'b0, s});
    op   = pos_t'({{(POS_W-8){1'b0}}, off});
    return ({1'b0, s} < half) ? sp + op : sp - op;
  endfunction

  function automatic logic outside(input pos_t v, input logic [DIM_W-1:0] d,
                                   input logic [7:0] m);
    pos_t mp;
    mp = pos_t'({{(POS_W-8){1'b0}}, m});
    return (v < mp) || (v >= to_pos(eff_dim(d)) - mp);
  endfunction

endpackage

// ===== hw/rtl/spt_if.sv =====
interface spt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_value;
  logic       frame_start;
  modport source(output valid, output pixel_value, output frame_start, input ready);
  modport sink(input valid, input pixel_value, input frame_start, output ready);
endinterface

interface spt_out_if;
  logic              valid;
  logic              ready;
  logic [11:0]       center_x;
  logic [11:0]       center_y;
  logic signed [3:0] step_x;
  logic signed [3:0] step_y;
  logic [13:0]       target_sum;
  logic [13:0]       sky_sum;
  logic signed [14:0] net_sum;
  logic [1:0]        track_status;
  modport source(output valid, output center_x, output center_y, output step_x,
                 output step_y, output target_sum, output sky_sum, output net_sum,
                 output track_status, input ready);
  modport sink(input valid, input center_x, input center_y, input step_x,
               input step_y, input target_sum, input sky_sum, input net_sum,
               input track_status, output ready);
endinterface

// ===== hw/rtl/spt_cfg.sv =====
module spt_cfg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output spt_pkg::spt_cfg_t cfg,
  output logic             reinit
);
  import spt_pkg::*;

  spt_cfg_t cfg_r;
  spt_reg_t idx;
  logic     wr;

  assign idx    = spt_reg_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign reinit = wr;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_FRAME_WIDTH:  cfg_r.frame_width  <= pwdata[11:0];
        REG_FRAME_HEIGHT: cfg_r.frame_height <= pwdata[11:0];
        REG_START_X:      cfg_r.start_x      <= pwdata[11:0];
        REG_START_Y:      cfg_r.start_y      <= pwdata[11:0];
        REG_SKIP_FRAMES:  cfg_r.skip_frames  <= pwdata[15:0];
        REG_EDGE_MARGIN:  cfg_r.edge_margin  <= pwdata[7:0];
        REG_SKY_OFFSET:   cfg_r.sky_offset   <= pwdata[7:0];
        REG_TRACK_ENABLE: cfg_r.track_enable <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FRAME_WIDTH:  prdata = {20'd0, cfg_r.frame_width};
      REG_FRAME_HEIGHT: prdata = {20'd0, cfg_r.frame_height};
      REG_START_X:      prdata = {20'd0, cfg_r.start_x};
      REG_START_Y:      prdata = {20'd0, cfg_r.start_y};
      REG_SKIP_FRAMES:  prdata = {16'd0, cfg_r.skip_frames};
      REG_EDGE_MARGIN:  prdata = {24'd0, cfg_r.edge_margin};
      REG_SKY_OFFSET:   prdata = {24'd0, cfg_r.sky_offset};
      REG_TRACK_ENABLE: prdata = {31'd0, cfg_r.track_enable};
    endcase
  end

endmodule

// ===== hw/rtl/spt_patch.sv =====
module spt_patch #(
  parameter int DEPTH = 225
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     clear,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [7:0]               wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [7:0]               rd_data
);
  localparam int AW = $clog2(DEPTH);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [7:0]       rd_q_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  // Entries not written this frame read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[rd_addr];
      if (clear) begin
        vld_r <= '0;
      end
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : 8'd0;

  logic [AW-1:0] unused_aw;
  assign unused_aw = wr_addr ^ rd_addr;

endmodule

// ===== hw/rtl/spt_seq.sv =====
module spt_seq #(
  parameter int SEARCH_RADIUS   = 4,
  parameter int APERTURE_RADIUS = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  spt_pkg::spt_cfg_t     cfg,
  input  logic                  reinit,
  input  logic                  finish,
  input  logic [spt_pkg::SUM_W-1:0] sky_sum,
  output logic [$clog2((2*(SEARCH_RADIUS+APERTURE_RADIUS)+1)**2)-1:0] rd_addr,
  input  logic [7:0]            rd_data,
  output logic                  busy,
  output spt_pkg::pos_t         star_x,
  output spt_pkg::pos_t         star_y,
  output spt_pkg::pos_t         sky_x,
  output spt_pkg::pos_t         sky_y,
  spt_out_if.source             out_if
);
  import spt_pkg::*;

  localparam int PR = SEARCH_RADIUS + APERTURE_RADIUS;
  localparam int PD = 2 * PR + 1;
  localparam int AW = $clog2(PD * PD);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_CHECK  = 5'b00100,
    S_SUM    = 5'b01000,
    S_EMIT   = 5'b10000
  } seq_state_t;

  seq_state_t       state_r;
  logic [15:0]      fc_r;
  logic             stopped_r;
  pos_t             star_x_r, star_y_r, sky_x_r, sky_y_r;
  logic [SUM_W-1:0] sky_sum_r, tsum_r;
  logic [7:0]       best_r;
  pos_t             bx_r, by_r, ix_r, iy_r;
  logic             iss_center_r, iss_done_r;
  logic             pend_vld_r, pend_first_r;
  pos_t             pend_dx_r, pend_dy_r;
  logic             out_valid_r;
  logic [CENTER_W-1:0] o_cx_r, o_cy_r;
  logic [STEP_W-1:0]   o_sx_r, o_sy_r;
  logic [TSUM_W-1:0]   o_ts_r, o_ss_r;
  logic [NET_W-1:0]    o_net_r;
  logic [1:0]          o_stat_r;

  pos_t lim, base_x, base_y, addr_full, nsx, nsy, drift_sq;
  logic tracked, lost, srch, sum_st;
  logic [SUM_W-1:0] net;

  assign srch   = (state_r == S_SEARCH);
  assign sum_st = (state_r == S_SUM);
  assign lim    = srch ? pos_t'(SEARCH_RADIUS) : pos_t'(APERTURE_RADIUS);
  assign base_x = srch ? '0 : bx_r;
  assign base_y = srch ? '0 : by_r;

  // One address generator serves both the search and the aperture sweep
  always_comb begin
    if (iss_center_r) begin
      addr_full = pos_t'(PR * PD + PR);
    end else begin
      addr_full = (base_y + iy_r + pos_t'(PR)) * pos_t'(PD) + (base_x + ix_r + pos_t'(PR));
    end
  end
  assign rd_addr = addr_full[AW-1:0];

  assign tracked  = cfg.track_enable && !stopped_r && (fc_r >= cfg.skip_frames);
  assign lost     = outside(star_x_r + bx_r, cfg.frame_width, cfg.edge_margin) ||
                    outside(star_y_r + by_r, cfg.frame_height, cfg.edge_margin) ||
                    outside(sky_x_r, cfg.frame_width, cfg.edge_margin) ||
                    outside(sky_y_r, cfg.frame_height, cfg.edge_margin);
  assign nsx      = star_x_r + bx_r;
  assign nsy      = star_y_r + by_r;
  assign drift_sq = bx_r * bx_r + by_r * by_r;
  assign net      = tsum_r - sky_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fc_r         <= '0;
      stopped_r    <= 1'b0;
      star_x_r     <= to_pos({1'b0, CFG_RESET.start_x});
      star_y_r     <= to_pos({1'b0, CFG_RESET.start_y});
      sky_x_r      <= sky_init(CFG_RESET.start_x, CFG_RESET.frame_width,
                               CFG_RESET.sky_offset);
      sky_y_r      <= sky_init(CFG_RESET.start_y, CFG_RESET.frame_height,
                               CFG_RESET.sky_offset);
      pend_vld_r   <= 1'b0;
      iss_center_r <= 1'b0;
      iss_done_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (reinit) begin
        state_r      <= S_IDLE;
        fc_r         <= '0;
        stopped_r    <= 1'b0;
        star_x_r     <= to_pos({1'b0, cfg.start_x});
        star_y_r     <= to_pos({1'b0, cfg.start_y});
        sky_x_r      <= sky_init(cfg.start_x, cfg.frame_width, cfg.sky_offset);
        sky_y_r      <= sky_init(cfg.start_y, cfg.frame_height, cfg.sky_offset);
        pend_vld_r   <= 1'b0;
        iss_center_r <= 1'b0;
      end else begin
        unique case (state_r)
          S_IDLE: begin
            if (finish) begin
              if (fc_r != 16'hFFFF) begin
                fc_r <= fc_r + 16'd1;
              end
              if (tracked) begin
                state_r      <= S_SEARCH;
                sky_sum_r    <= sky_sum;
                iss_center_r <= 1'b1;
                iss_done_r   <= 1'b0;
                ix_r         <= pos_t'(-SEARCH_RADIUS);
                iy_r         <= pos_t'(-SEARCH_RADIUS);
                bx_r         <= '0;
                by_r         <= '0;
              end
            end
          end
          S_SEARCH, S_SUM: begin
            // Consume the word read last cycle
            if (pend_vld_r) begin
              if (srch) begin
                if (pend_first_r) begin
                  best_r <= rd_data;
                end else if (rd_data > best_r) begin
                  best_r <= rd_data;
                  bx_r   <= pend_dx_r;
                  by_r   <= pend_dy_r;
                end
              end else begin
                tsum_r <= tsum_r + SUM_W'(rd_data);
              end
            end
            // Issue the next read
            if (!iss_done_r) begin
              pend_vld_r   <= 1'b1;
              pend_first_r <= iss_center_r;
              pend_dx_r    <= ix_r;
              pend_dy_r    <= iy_r;
              if (iss_center_r) begin
                iss_center_r <= 1'b0;
              end else if (ix_r == lim) begin
                ix_r <= -lim;
                if (iy_r == lim) begin
                  iss_done_r <= 1'b1;
                end else begin
                  iy_r <= iy_r + pos_t'(1);
                end
              end else begin
                ix_r <= ix_r + pos_t'(1);
              end
            end else begin
              pend_vld_r <= 1'b0;
              if (pend_vld_r) begin
                state_r <= sum_st ? S_EMIT : S_CHECK;
              end
            end
          end
          S_CHECK: begin
            if (lost) begin
              if (!out_valid_r || out_if.ready) begin
                stopped_r   <= 1'b1;
                out_valid_r <= 1'b1;
                o_cx_r      <= star_x_r[CENTER_W-1:0];
                o_cy_r      <= star_y_r[CENTER_W-1:0];
                o_sx_r      <= '0;
                o_sy_r      <= '0;
                o_ts_r      <= '0;
                o_ss_r      <= '0;
                o_net_r     <= '0;
                o_stat_r    <= STAT_EDGE;
                state_r     <= S_IDLE;
              end
            end else begin
              state_r    <= S_SUM;
              tsum_r     <= '0;
              ix_r       <= pos_t'(-APERTURE_RADIUS);
              iy_r       <= pos_t'(-APERTURE_RADIUS);
              iss_done_r <= 1'b0;
            end
          end
          S_EMIT: begin
            if (!out_valid_r || out_if.ready) begin
              star_x_r    <= nsx;
              star_y_r    <= nsy;
              sky_x_r     <= sky_x_r + bx_r;
              sky_y_r     <= sky_y_r + by_r;
              out_valid_r <= 1'b1;
              o_cx_r      <= nsx[CENTER_W-1:0];
              o_cy_r      <= nsy[CENTER_W-1:0];
              o_sx_r      <= bx_r[STEP_W-1:0];
              o_sy_r      <= by_r[STEP_W-1:0];
              o_ts_r      <= tsum_r[TSUM_W-1:0];
              o_ss_r      <= sky_sum_r[TSUM_W-1:0];
              o_net_r     <= net[NET_W-1:0];
              if (drift_sq > pos_t'(DRIFT_LIMIT_SQ)) begin
                o_stat_r  <= STAT_DRIFT;
                stopped_r <= 1'b1;
              end else begin
                o_stat_r  <= STAT_TRACKED;
              end
              state_r <= S_IDLE;
            end
          end
          default: state_r <= S_IDLE;
        endcase
      end
    end
  end

  assign busy   = (state_r != S_IDLE);
  assign star_x = star_x_r;
  assign star_y = star_y_r;
  assign sky_x  = sky_x_r;
  assign sky_y  = sky_y_r;

  assign out_if.valid        = out_valid_r;
  assign out_if.center_x     = o_cx_r;
  assign out_if.center_y     = o_cy_r;
  assign out_if.step_x       = o_sx_r;
  assign out_if.step_y       = o_sy_r;
  assign out_if.target_sum   = o_ts_r;
  assign out_if.sky_sum      = o_ss_r;
  assign out_if.net_sum      = o_net_r;
  assign out_if.track_status = o_stat_r;

endmodule

// ===== hw/rtl/star_peak_track_photometry_top.sv =====
// Channel | Dir | Words                      | Handshake
// in_if   | in  | pixel_value, frame_start   | valid/ready
// out_if  | out | center, step, sums, status | valid/ready
// apb     | in  | 8 registers at 4*i         | psel/penable, pready high
//
// Pixels are taken one per cycle while the finish sequencer is idle.
// After the last pixel of a tracked frame the sequencer holds ready low while it
// sweeps the search window and then the aperture, one read at a time through the
// single patch memory read port.
// A waiting result stalls the emit step and an edge-loss report; rst_n is synchronous.
module star_peak_track_photometry_top #(
  parameter int SEARCH_RADIUS   = 4,
  parameter int APERTURE_RADIUS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  spt_in_if.sink      in_if,
  spt_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import spt_pkg::*;

  localparam int PR = SEARCH_RADIUS + APERTURE_RADIUS;
  localparam int PD = 2 * PR + 1;
  localparam int AW = $clog2(PD * PD);

  spt_cfg_t cfg;
  logic     reinit;
  logic     busy;
  pos_t     star_x, star_y, sky_x, sky_y;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  logic [DIM_W-1:0] col_r, row_r, c, r;
  logic [SUM_W-1:0] sky_acc_r, sky_nxt;
  logic [DIM_W:0]   ew, eh;
  logic accept, active, last_col, last_row, finish, in_patch, in_sky, wr_en, clear;
  pos_t px, py, sdx, sdy, waddr_full;

  spt_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg, .reinit
  );

  assign ew     = eff_dim(cfg.frame_width);
  assign eh     = eff_dim(cfg.frame_height);
  assign accept = in_if.valid && in_if.ready;
  assign c      = in_if.frame_start ? '0 : col_r;
  assign r      = in_if.frame_start ? '0 : row_r;
  assign active = ({1'b0, r} < eh);

  assign px  = to_pos({1'b0, c}) - star_x + pos_t'(PR);
  assign py  = to_pos({1'b0, r}) - star_y + pos_t'(PR);
  assign sdx = to_pos({1'b0, c}) - sky_x;
  assign sdy = to_pos({1'b0, r}) - sky_y;
  assign in_patch = (px >= 0) && (px < pos_t'(PD)) && (py >= 0) && (py < pos_t'(PD));
  assign in_sky   = (sdx >= pos_t'(-APERTURE_RADIUS)) && (sdx <= pos_t'(APERTURE_RADIUS)) &&
                    (sdy >= pos_t'(-APERTURE_RADIUS)) && (sdy <= pos_t'(APERTURE_RADIUS));
  assign waddr_full = py * pos_t'(PD) + px;

  assign last_col = ({1'b0, c} + (DIM_W+1)'(1)) >= ew;
  assign last_row = ({1'b0, r} + (DIM_W+1)'(1)) >= eh;
  assign finish   = accept && active && last_col && last_row;
  assign wr_en    = accept && active && in_patch;
  assign clear    = reinit || (accept && in_if.frame_start);
  assign sky_nxt  = (in_if.frame_start ? '0 : sky_acc_r) +
                    ((in_sky && active) ? SUM_W'(in_if.pixel_value) : '0);

  assign in_if.ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      sky_acc_r <= '0;
    end else if (reinit) begin
      col_r     <= '0;
      row_r     <= '0;
      sky_acc_r <= '0;
    end else if (accept && active) begin
      sky_acc_r <= sky_nxt;
      if (last_col) begin
        col_r <= '0;
        row_r <= r + DIM_W'(1);
      end else begin
        col_r <= c + DIM_W'(1);
        row_r <= r;
      end
    end
  end

  spt_patch #(.DEPTH(PD * PD)) u_patch (
    .clk, .rst_n, .clear, .wr_en,
    .wr_addr(waddr_full[AW-1:0]),
    .wr_data(in_if.pixel_value),
    .rd_addr, .rd_data
  );

  spt_seq #(.SEARCH_RADIUS(SEARCH_RADIUS), .APERTURE_RADIUS(APERTURE_RADIUS)) u_seq (
    .clk, .rst_n, .cfg, .reinit, .finish, .sky_sum(sky_nxt), .rd_addr, .rd_data,
    .busy, .star_x, .star_y, .sky_x, .sky_y, .out_if
  );

`ifndef NO_ASSERTIONS
  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    finish |-> !busy) else $error("frame finished while sequencer busy");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> out_if.track_status != 2'd3) else $error("bad status code");
  a_edge_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.track_status == STAT_EDGE |->
    out_if.target_sum == '0 && out_if.net_sum == '0 && out_if.step_x == '0)
    else $error("edge loss result carries data");
`endif

endmodule
